// File: hw/rtl/crc15pec_pkg.sv
// Shared types, constants and the CRC-15 table function for the PEC appender.
package crc15pec_pkg;

  localparam logic [15:0] PEC_POLY       = 16'h4599;
  localparam logic [15:0] PEC_SEED_RESET = 16'h0010;

  // One queued byte with its end-of-message flag and, on the last byte, the code.
  typedef struct packed {
    logic [15:0] code;
    logic        eom;
    logic [7:0]  data;
  } entry_t;

  // Which beat of the current queue entry the back end emits next.
  typedef enum logic [1:0] {
    BEAT_DATA = 2'd0,
    BEAT_HI   = 2'd1,
    BEAT_LO   = 2'd2
  } beat_e;

  // CRC-15 table entry in 16-bit form (index 1 gives 16'hc599).
  function automatic logic [15:0] table_entry(input logic [7:0] idx);
    logic [15:0] r;
    r = {1'b0, idx, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ PEC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/crc15pec_front.sv
// Front end: accepts message bytes, updates the remainder, queues bytes and codes.
module crc15pec_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_data_i,
  input  logic                  in_eom_i,
  input  logic                  q_full_i,
  output logic                  in_ready_o,
  output logic                  push_o,
  output crc15pec_pkg::entry_t  push_entry_o
);

  logic [15:0] seed_q, seed_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  idx;
  logic [15:0] rem_next;
  logic        accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  assign idx      = rem_q[14:7] ^ in_data_i;
  assign rem_next = {rem_q[7:0], 8'h00} ^ crc15pec_pkg::table_entry(idx);

  always_comb begin
    seed_d = seed_q;
    rem_d  = rem_q;
    if (cfg_valid_i) begin
      seed_d = cfg_data_i;
      rem_d  = cfg_data_i;
    end else if (accept) begin
      rem_d = in_eom_i ? seed_q : rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= crc15pec_pkg::PEC_SEED_RESET;
      rem_q  <= crc15pec_pkg::PEC_SEED_RESET;
    end else begin
      seed_q <= seed_d;
      rem_q  <= rem_d;
    end
  end

  assign push_o            = accept;
  assign push_entry_o.data = in_data_i;
  assign push_entry_o.eom  = in_eom_i;
  assign push_entry_o.code = {rem_next[14:0], 1'b0};

  // after the last byte of a message the remainder restarts from the seed
  a_reload_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_eom_i && !cfg_valid_i |=> rem_q == $past(seed_q))
    else $error("remainder not reloaded after end of message");

endmodule

// File: hw/rtl/crc15pec_fifo.sv
// Small register queue between the front and back ends.
module crc15pec_fifo #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FULL_CNT);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue count out of range");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + CW'(1))
    else $error("queue count did not follow a push");

endmodule

// File: hw/rtl/crc15pec_back.sv
// Back end: turns queue entries into output beats (data byte, then code bytes).
module crc15pec_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  crc15pec_pkg::entry_t  head_i,
  output logic                  pop_o,
  input  logic                  m_axis_tready,
  output logic                  m_axis_tvalid,
  output logic [7:0]            m_axis_tdata,
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  crc15pec_pkg::beat_e beat_q, beat_d;
  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       code_q, last_q;
  logic       load;
  logic [7:0] beat_byte;
  logic       beat_code, beat_last;

  assign load = ~q_empty_i & (~valid_q | m_axis_tready);

  // next beat
  always_comb begin
    beat_d = beat_q;
    if (load) begin
      case (beat_q)
        crc15pec_pkg::BEAT_DATA: begin
          beat_d = head_i.eom ? crc15pec_pkg::BEAT_HI : crc15pec_pkg::BEAT_DATA;
        end
        crc15pec_pkg::BEAT_HI: begin
          beat_d = crc15pec_pkg::BEAT_LO;
        end
        crc15pec_pkg::BEAT_LO: begin
          beat_d = crc15pec_pkg::BEAT_DATA;
        end
        default: begin
          beat_d = crc15pec_pkg::BEAT_DATA;
        end
      endcase
    end
  end

  // beat contents and queue pop
  always_comb begin
    beat_byte = head_i.data;
    beat_code = 1'b0;
    beat_last = 1'b1;
    pop_o     = 1'b0;
    case (beat_q)
      crc15pec_pkg::BEAT_DATA: begin
        beat_byte = head_i.data;
        beat_code = 1'b0;
        beat_last = ~head_i.eom;
        pop_o     = load & ~head_i.eom;
      end
      crc15pec_pkg::BEAT_HI: begin
        beat_byte = head_i.code[15:8];
        beat_code = 1'b1;
        beat_last = 1'b0;
      end
      crc15pec_pkg::BEAT_LO: begin
        beat_byte = head_i.code[7:0];
        beat_code = 1'b1;
        beat_last = 1'b1;
        pop_o     = load;
      end
      default: begin
        beat_byte = head_i.data;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= crc15pec_pkg::BEAT_DATA;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= beat_byte;
      code_q <= beat_code;
      last_q <= beat_last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = code_q;
  assign m_axis_tlast  = last_q;

  // mid-entry the data beat has already been loaded into the output register
  a_mid_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q != crc15pec_pkg::BEAT_DATA |-> valid_q)
    else $error("code beat pending without a loaded output");

  // the entry is held in the queue until its low code byte is sent
  a_hold_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q != crc15pec_pkg::BEAT_DATA |-> !q_empty_i)
    else $error("queue drained while code beats pending");

endmodule

// File: hw/rtl/crc15_pec_appender.sv
// Top level of the CRC-15 PEC appender: front end, queue and back end.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------
//  s_axis   | in        | tvalid / tready      | tdata = data_byte, tlast = end_of_message
//  m_axis   | out       | tvalid / tready      | tdata = out_byte, tuser = is_code,
//           |           |                      | tlast = last_of_run
//  cfg      | in        | cfg_valid_i/_ready_o | cfg_data_i = pec_seed
//
// One input byte is taken per cycle while the queue has room; the remainder
// update (table lookup and XOR) finishes in that cycle. The output register sends
// one beat per cycle while m_axis_tready is high: one beat per byte, three for a
// message's last byte, so the output side sets the sustained rate. Reset loads the
// seed 16'h0010 and empties the queue; a seed write also restarts the remainder.
// Either side may stall independently; the queue holds FIFO_DEPTH entries.
module crc15_pec_appender #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,      // [15:0] pec_seed
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
  output logic        m_axis_tuser,    // [0] is_code
  output logic        m_axis_tlast
);

  localparam int EW = $bits(crc15pec_pkg::entry_t);

  logic                 q_full, q_empty, push, pop;
  crc15pec_pkg::entry_t push_entry, head;
  logic [EW-1:0]        head_bits;

  assign cfg_ready_o = 1'b1;

  crc15pec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_data_i    (s_axis_tdata),
    .in_eom_i     (s_axis_tlast),
    .q_full_i     (q_full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  crc15pec_fifo #(
    .WIDTH (EW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head_bits),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  assign head = crc15pec_pkg::entry_t'(head_bits);

  crc15pec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: bench/crc15_pec_appender_test.sv
// Self-checking testbench for the CRC-15 PEC appender: bytes, seed writes, code beats.
`timescale 1ns / 100ps

module crc15_pec_appender_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_BYTES = 80;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       is_code;
    logic       last;
  } beat_t;

  // directed row: optional seed write ahead of the byte, typed code where obvious
  typedef struct packed {
    bit          wr_seed;
    logic [15:0] seed;
    logic [7:0]  data;
    logic        eom;
    bit          known;
    logic [15:0] code;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [15] = '{
    '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, 16'h2000},  // reset seed, zero byte
    '{1'b1, 16'h0000, 8'h00, 1'b1, 1'b1, 16'h0000},  // zero seed, zero byte
    '{1'b0, 16'h0000, 8'h01, 1'b1, 1'b1, 16'h8b32},  // table index 1 -> 0xc599
    '{1'b0, 16'h0000, 8'hff, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h80, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h7f, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h55, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'haa, 1'b1, 1'b0, 16'h0000},
    '{1'b1, 16'hffff, 8'hff, 1'b1, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h12, 1'b0, 1'b0, 16'h0000},  // message cut by the seed write below
    '{1'b1, 16'h0010, 8'h34, 1'b1, 1'b0, 16'h0000},
    '{1'b1, 16'h8000, 8'h00, 1'b1, 1'b1, 16'h0000},  // seed bit 15 has no effect
    '{1'b1, 16'h7fff, 8'hc3, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h3c, 1'b1, 1'b0, 16'h0000}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = 16'h0000;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;            // [7:0] out_byte
  logic        m_axis_tuser;            // [0] is_code
  logic        m_axis_tlast;

  crc15_pec_appender uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // predictor state: bits 14:0 of the remainder, bit 15 never reaches a result
  logic [14:0] pec_crc      = crc15pec_pkg::PEC_SEED_RESET[14:0];
  logic [15:0] pec_seed_set = crc15pec_pkg::PEC_SEED_RESET;
  beat_t       pec_beats_q[$];

  int    mismatches  = 0;
  int    cycle_count = 0;
  bit    idle_on     = 1'b1;
  int    rx_hold     = 0;
  int    rx_calm     = 0;
  bit    out_fire    = 1'b0;
  beat_t out_got;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("crc15_pec_appender: mismatch");
      $finish;
    end
  end

  // receiver stalls: random bursts, with calm stretches in between
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      rx_calm = $urandom_range(20, 60);
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      rx_hold = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // outputs are settled at the falling edge; the transaction lands on the next rise
  always @(negedge clk_i) begin
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    out_got  = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
  end

  always @(posedge clk_i) begin : check_out
    beat_t want;
    if (out_fire) begin
      if (pec_beats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected beat: byte %02h code %0b last %0b",
                   out_got.data, out_got.is_code, out_got.last);
        end
      end else begin
        want = pec_beats_q.pop_front();
        if (out_got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("beat mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     want.data, want.is_code, want.last,
                     out_got.data, out_got.is_code, out_got.last);
          end
        end
      end
    end
  end

  // absorb one byte MSB first into the 15-bit CRC and queue the beats it causes
  task automatic absorb_byte(input logic [7:0] d, input logic eom, input bit known,
                             input logic [15:0] typed_code);
    logic [15:0] pec;
    for (int b = 7; b >= 0; b--) begin
      if (pec_crc[14] ^ d[b]) begin
        pec_crc = {pec_crc[13:0], 1'b0} ^ crc15pec_pkg::PEC_POLY[14:0];
      end else begin
        pec_crc = {pec_crc[13:0], 1'b0};
      end
    end
    pec = known ? typed_code : {pec_crc, 1'b0};
    pec_beats_q.push_back('{d, 1'b0, !eom});
    if (eom) begin
      pec_beats_q.push_back('{pec[15:8], 1'b1, 1'b0});
      pec_beats_q.push_back('{pec[7:0], 1'b1, 1'b1});
      pec_crc = pec_seed_set[14:0];
    end
  endtask

  // called at a rising edge; returns at the edge of the transaction
  task automatic send_byte(input logic [7:0] d, input logic eom, input bit gappy,
                           input bit known, input logic [15:0] typed_code);
    if (gappy && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= eom;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    absorb_byte(d, eom, known, typed_code);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pec_beats_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    pec_seed_set = value;
    pec_crc      = value[14:0];
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int          sent;
    int          msg_len;
    bit          gappy;
    logic [15:0] seed;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].wr_seed) begin
        wait_drained();
        write_seed(DIRECTED_ROWS[i].seed);
      end
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].eom, 1'($urandom_range(0, 1)),
                DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].code);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        1:       seed = 16'h0000;
        2:       seed = 16'hffff;
        4:       seed = crc15pec_pkg::PEC_SEED_RESET;
        default: seed = 16'($urandom_range(0, 65535));
      endcase
      wait_drained();
      write_seed(seed);
      idle_on = (ph != RAND_PHASES - 1);  // final phase runs at full rate
      sent = 0;
      // a phase may end inside a message; the next seed write restarts it
      while (sent < PHASE_BYTES) begin
        msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        gappy   = idle_on && ($urandom_range(0, 3) != 0);
        for (int k = 0; k < msg_len && sent < PHASE_BYTES; k++) begin
          send_byte(8'($urandom_range(0, 255)), k == msg_len - 1, gappy, 1'b0, 16'h0000);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pec_beats_q.size() == 0) begin
      $display("crc15_pec_appender: match");
    end else begin
      $display("crc15_pec_appender: mismatch");
    end
    $finish;
  end

endmodule
